FILE: rtl/core/bea_pkg.sv
package bea_pkg;

  typedef enum logic {
    OP_MARK  = 1'b0,
    OP_ALLOC = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_TOO_MANY   = 2'd2,
    ST_ZERO_COUNT = 2'd3
  } status_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_LOG_BAND = 2'd0;
  localparam logic [1:0] CFG_TOTAL    = 2'd1;
  localparam logic [1:0] CFG_HINT     = 2'd2;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned ADDR_W    = 37;  // band << log + start_bit + count
  localparam int unsigned CUR_W     = 16;
  localparam int unsigned COUNT_W   = 17;
  localparam int unsigned USED_W    = 20;
  localparam int unsigned EXT_CAP   = 7;
  localparam int unsigned EXT_IDX_W = 3;
  localparam logic [COUNT_W-1:0] SCAN_LIMIT_MAX = 17'd65536;

  typedef struct packed {
    op_t                op;
    logic [3:0]         band;
    logic [15:0]        start_bit;
    logic [COUNT_W-1:0] count;
    logic               count_as_used;
  } in_word_t;

  typedef struct packed {
    logic [15:0]          extent_start;
    logic [COUNT_W-1:0]   extent_length;
    logic [EXT_IDX_W-1:0] extent_index;
    logic                 last;
    status_t              status;
    logic [USED_W-1:0]    used_blocks;
  } out_word_t;

  // Control from the sequencer to the extent recorder
  typedef struct packed {
    logic             clr;
    logic             take;
    logic [CUR_W-1:0] blk;
  } ext_ctl_t;

  typedef struct packed {
    logic                 overflow;
    logic [EXT_IDX_W-1:0] last_idx;
  } ext_stat_t;

endpackage

FILE: rtl/core/bea_ram.sv
module bea_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/bea_ext.sv
module bea_ext #(
  parameter int unsigned MAX_EXTENTS = 6
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bea_pkg::ext_ctl_t              ctl,
  input  logic [bea_pkg::EXT_IDX_W-1:0]  rd_idx,
  output bea_pkg::ext_stat_t             stat,
  output logic [bea_pkg::CUR_W-1:0]      rd_start,
  output logic [bea_pkg::COUNT_W-1:0]    rd_len
);

  localparam int unsigned EXT_LIMIT = (MAX_EXTENTS > 7) ? 7 : MAX_EXTENTS;

  logic [bea_pkg::CUR_W-1:0]     st_r  [bea_pkg::EXT_CAP];
  logic [bea_pkg::COUNT_W-1:0]   len_r [bea_pkg::EXT_CAP];
  logic [bea_pkg::EXT_IDX_W-1:0] n_r, n_nxt;
  logic                          empty_r, empty_nxt;
  logic [bea_pkg::COUNT_W-1:0]   end_r, end_nxt;
  logic [bea_pkg::COUNT_W-1:0]   cur_len_r, cur_len_nxt;
  logic [bea_pkg::COUNT_W-1:0]   blk_ext;
  logic                          adjacent;
  logic                          overflow;
  logic                          wr_en;
  logic                          wr_new;
  logic [bea_pkg::EXT_IDX_W-1:0] wr_idx;

  assign blk_ext  = bea_pkg::COUNT_W'(ctl.blk);
  assign adjacent = !empty_r && (blk_ext == end_r);
  assign overflow = ctl.take && !empty_r && !adjacent &&
                    ((4'(n_r) + 4'd1) >= 4'(EXT_LIMIT));

  always_comb begin
    n_nxt       = n_r;
    empty_nxt   = empty_r;
    end_nxt     = end_r;
    cur_len_nxt = cur_len_r;
    wr_en       = 1'b0;
    wr_new      = 1'b0;
    wr_idx      = n_r;
    if (ctl.clr) begin
      n_nxt     = '0;
      empty_nxt = 1'b1;
    end else if (ctl.take && !overflow) begin
      wr_en = 1'b1;
      if (adjacent) begin
        cur_len_nxt = cur_len_r + 17'd1;
        end_nxt     = end_r + 17'd1;
      end else begin
        // open a new extent; the first one sits at slot zero
        wr_new      = 1'b1;
        wr_idx      = empty_r ? n_r : n_r + 3'd1;
        n_nxt       = wr_idx;
        empty_nxt   = 1'b0;
        cur_len_nxt = 17'd1;
        end_nxt     = blk_ext + 17'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r     <= '0;
      empty_r <= 1'b1;
    end else begin
      n_r     <= n_nxt;
      empty_r <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    end_r     <= end_nxt;
    cur_len_r <= cur_len_nxt;
    if (wr_en) begin
      len_r[wr_idx] <= cur_len_nxt;
      if (wr_new) begin
        st_r[wr_idx] <= ctl.blk;
      end
    end
  end

  assign stat.overflow = overflow;
  assign stat.last_idx = n_r;
  assign rd_start      = st_r[rd_idx];
  assign rd_len        = len_r[rd_idx];

endmodule

FILE: rtl/core/bitmap_extent_allocator.sv
// Free-block bitmap allocator. One bit per block lives in a 32-bit wide RAM
// of (NUM_BLOCKS+31)/32 words. After reset the RAM is swept to zero, one word
// a cycle, and no request is taken until the sweep ends; configuration writes
// are taken throughout. Requests are handled one at a time. A mark reads and
// writes back each 32-bit bitmap word it touches. An allocate examines one
// block per cycle from the search cursor, but stops to read, load and write
// back every bitmap word it enters, so its time follows the number of blocks
// passed over, not the count alone. Result words then leave one per cycle
// while out_stall is low. Results: one word for a mark, a zero count or a
// failed allocate, and one word per extent for a successful allocate, the
// last one flagged.
module bitmap_extent_allocator #(
  parameter int unsigned NUM_BLOCKS  = 65536,
  parameter int unsigned MAX_EXTENTS = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bea_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bea_pkg::out_word_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [16:0]         cfg_wdata
);

  localparam int unsigned MAP_WORDS = (NUM_BLOCKS + 31) / 32;
  localparam int unsigned AW        = $clog2(MAP_WORDS);
  localparam int unsigned TAIL      = NUM_BLOCKS % 32;
  localparam logic [31:0] LAST_KEEP = (TAIL == 0) ? {32{1'b1}}
                                                  : ~({32{1'b1}} << TAIL);
  localparam int unsigned EXT_LIMIT = (MAX_EXTENTS > 7) ? 7 : MAX_EXTENTS;

  typedef enum logic [8:0] {
    S_CLEAR    = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_MARK_RD  = 9'b000000100,
    S_MARK_WR  = 9'b000001000,
    S_SCAN_RD  = 9'b000010000,
    S_SCAN_LD  = 9'b000100000,
    S_SCAN_BIT = 9'b001000000,
    S_SCAN_WB  = 9'b010000000,
    S_EMIT     = 9'b100000000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [4:0]                      log_r, log_nxt;
  logic [bea_pkg::COUNT_W-1:0]     total_r, total_nxt;
  logic [bea_pkg::CUR_W-1:0]       cursor_r, cursor_nxt;
  logic [bea_pkg::USED_W-1:0]      used_r, used_nxt;
  logic [AW-1:0]                   clr_addr_r, clr_addr_nxt;
  logic [bea_pkg::ADDR_W-1:0]      mk_addr_r, mk_addr_nxt;
  logic [bea_pkg::COUNT_W-1:0]     mk_rem_r, mk_rem_nxt;
  logic [bea_pkg::COUNT_W-1:0]     limit_r, limit_nxt;
  logic [bea_pkg::COUNT_W-1:0]     al_rem_r, al_rem_nxt;
  logic [bea_pkg::WORD_W-1:0]      word_r, word_nxt;
  logic [AW-1:0]                   word_addr_r, word_addr_nxt;
  logic                            wb_ok_r, wb_ok_nxt;
  logic                            wb_cont_r, wb_cont_nxt;
  bea_pkg::status_t                res_status_r, res_status_nxt;
  logic [bea_pkg::EXT_IDX_W-1:0]   emit_idx_r, emit_idx_nxt;
  logic                            out_valid_r, out_valid_nxt;
  bea_pkg::out_word_t              out_r, out_nxt;

  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [bea_pkg::WORD_W-1:0]      ram_wdata;
  logic [AW-1:0]                   ram_raddr;
  logic [bea_pkg::WORD_W-1:0]      ram_rdata;

  bea_pkg::ext_ctl_t               ext_ctl;
  bea_pkg::ext_stat_t              ext_stat;
  logic [bea_pkg::EXT_IDX_W-1:0]   ext_rd_idx;
  logic [bea_pkg::CUR_W-1:0]       ext_start;
  logic [bea_pkg::COUNT_W-1:0]     ext_len;

  logic                            in_acc;
  logic [bea_pkg::COUNT_W-1:0]     used_add;
  logic [bea_pkg::USED_W:0]        used_sum;
  logic [bea_pkg::ADDR_W-1:0]      cur_ext;
  logic                            cur_oob;
  logic [bea_pkg::CUR_W-1:0]       cur_inc;
  logic [4:0]                      scan_off;
  logic                            scan_used;
  logic [4:0]                      mk_off;
  logic [5:0]                      mk_room;
  logic [5:0]                      mk_n;
  logic [bea_pkg::WORD_W-1:0]      mk_mask;
  logic [AW-1:0]                   mk_word;

  bea_ram #(
    .WIDTH(bea_pkg::WORD_W),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  bea_ext #(
    .MAX_EXTENTS(MAX_EXTENTS)
  ) u_ext (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ext_ctl),
    .rd_idx  (ext_rd_idx),
    .stat    (ext_stat),
    .rd_start(ext_start),
    .rd_len  (ext_len)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign cur_ext   = bea_pkg::ADDR_W'(cursor_r);
  assign cur_oob   = cur_ext >= bea_pkg::ADDR_W'(NUM_BLOCKS);
  assign cur_inc   = cursor_r + 16'd1;
  assign scan_off  = cursor_r[4:0];
  assign scan_used = word_r[scan_off] || cur_oob;

  assign mk_off  = mk_addr_r[4:0];
  assign mk_room = 6'd32 - {1'b0, mk_off};
  assign mk_n    = (mk_rem_r < bea_pkg::COUNT_W'(mk_room)) ? mk_rem_r[5:0] : mk_room;
  assign mk_word = mk_addr_r[AW+4:5];
  assign mk_mask = (~({32{1'b1}} << mk_n) << mk_off) &
                   ((mk_word == AW'(MAP_WORDS - 1)) ? LAST_KEEP : {32{1'b1}});

  assign ext_rd_idx = (state_r == S_EMIT) ? emit_idx_r + 3'd1 : 3'd0;

  assign used_sum = (bea_pkg::USED_W + 1)'(used_r) + (bea_pkg::USED_W + 1)'(used_add);
  assign used_nxt = used_sum[bea_pkg::USED_W] ? {bea_pkg::USED_W{1'b1}}
                                              : used_sum[bea_pkg::USED_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    log_nxt        = log_r;
    total_nxt      = total_r;
    cursor_nxt     = cursor_r;
    clr_addr_nxt   = clr_addr_r;
    mk_addr_nxt    = mk_addr_r;
    mk_rem_nxt     = mk_rem_r;
    limit_nxt      = limit_r;
    al_rem_nxt     = al_rem_r;
    word_nxt       = word_r;
    word_addr_nxt  = word_addr_r;
    wb_ok_nxt      = wb_ok_r;
    wb_cont_nxt    = wb_cont_r;
    res_status_nxt = res_status_r;
    emit_idx_nxt   = emit_idx_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    used_add       = '0;
    ram_we         = 1'b0;
    ram_waddr      = word_addr_r;
    ram_wdata      = word_r;
    ram_raddr      = cur_ext[AW+4:5];
    ext_ctl.clr    = 1'b0;
    ext_ctl.take   = 1'b0;
    ext_ctl.blk    = cursor_r;

    if (cfg_valid) begin
      case (cfg_index)
        bea_pkg::CFG_LOG_BAND: log_nxt = cfg_wdata[4:0];
        bea_pkg::CFG_TOTAL:    total_nxt = cfg_wdata;
        bea_pkg::CFG_HINT:     cursor_nxt = cfg_wdata[15:0];
        default:               ;
      endcase
    end

    case (state_r)
      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(MAP_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          if (in_data.count == '0) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{extent_start: '0, extent_length: '0, extent_index: '0,
                              last: 1'b1, status: bea_pkg::ST_ZERO_COUNT,
                              used_blocks: used_r};
            state_nxt     = S_EMIT;
          end else if (in_data.op == bea_pkg::OP_MARK) begin
            mk_addr_nxt = (bea_pkg::ADDR_W'(in_data.band) << log_r) +
                          bea_pkg::ADDR_W'(in_data.start_bit);
            mk_rem_nxt  = in_data.count;
            if (in_data.count_as_used) begin
              used_add = in_data.count;
            end
            state_nxt = S_MARK_RD;
          end else begin
            limit_nxt   = (total_r > bea_pkg::SCAN_LIMIT_MAX) ? bea_pkg::SCAN_LIMIT_MAX
                                                              : total_r;
            al_rem_nxt  = in_data.count;
            ext_ctl.clr = 1'b1;
            state_nxt   = S_SCAN_RD;
          end
        end
      end

      S_MARK_RD: begin
        ram_raddr = mk_word;
        // bits past the map are dropped, and the run only climbs
        if (mk_rem_r == '0 || mk_addr_r >= bea_pkg::ADDR_W'(NUM_BLOCKS)) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{extent_start: '0, extent_length: '0, extent_index: '0,
                            last: 1'b1, status: bea_pkg::ST_OK, used_blocks: used_r};
          state_nxt     = S_EMIT;
        end else begin
          state_nxt = S_MARK_WR;
        end
      end

      S_MARK_WR: begin
        ram_we      = 1'b1;
        ram_waddr   = mk_word;
        ram_wdata   = ram_rdata | mk_mask;
        mk_addr_nxt = mk_addr_r + bea_pkg::ADDR_W'(mk_n);
        mk_rem_nxt  = mk_rem_r - bea_pkg::COUNT_W'(mk_n);
        state_nxt   = S_MARK_RD;
      end

      S_SCAN_RD: begin
        state_nxt = S_SCAN_LD;
      end

      S_SCAN_LD: begin
        word_nxt      = ram_rdata;
        word_addr_nxt = cur_ext[AW+4:5];
        wb_ok_nxt     = (cur_ext >> 5) < bea_pkg::ADDR_W'(MAP_WORDS);
        state_nxt     = S_SCAN_BIT;
      end

      S_SCAN_BIT: begin
        cursor_nxt = cur_inc;
        if (scan_used) begin
          if ((bea_pkg::COUNT_W'(cur_inc) + 17'd1) >= limit_r) begin
            wb_cont_nxt    = 1'b0;
            res_status_nxt = bea_pkg::ST_NO_SPACE;
            state_nxt      = S_SCAN_WB;
          end else if (cur_inc[4:0] == 5'd0) begin
            wb_cont_nxt = 1'b1;
            state_nxt   = S_SCAN_WB;
          end
        end else begin
          word_nxt[scan_off] = 1'b1;
          used_add           = 17'd1;
          ext_ctl.take       = 1'b1;
          al_rem_nxt         = al_rem_r - 17'd1;
          if (ext_stat.overflow) begin
            wb_cont_nxt    = 1'b0;
            res_status_nxt = bea_pkg::ST_TOO_MANY;
            state_nxt      = S_SCAN_WB;
          end else if (al_rem_r == 17'd1) begin
            wb_cont_nxt    = 1'b0;
            res_status_nxt = bea_pkg::ST_OK;
            state_nxt      = S_SCAN_WB;
          end else if (cur_inc[4:0] == 5'd0) begin
            wb_cont_nxt = 1'b1;
            state_nxt   = S_SCAN_WB;
          end
        end
      end

      S_SCAN_WB: begin
        ram_we = wb_ok_r;
        if (wb_cont_r) begin
          state_nxt = S_SCAN_RD;
        end else begin
          out_valid_nxt = 1'b1;
          emit_idx_nxt  = '0;
          state_nxt     = S_EMIT;
          if (res_status_r == bea_pkg::ST_OK) begin
            out_nxt = '{extent_start: ext_start, extent_length: ext_len,
                        extent_index: '0, last: (ext_stat.last_idx == '0),
                        status: bea_pkg::ST_OK, used_blocks: used_r};
          end else begin
            out_nxt = '{extent_start: '0, extent_length: '0, extent_index: '0,
                        last: 1'b1, status: res_status_r, used_blocks: used_r};
          end
        end
      end

      S_EMIT: begin
        if (out_valid_r && !out_stall) begin
          if (out_r.last) begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            // advance to the next extent word
            emit_idx_nxt = ext_rd_idx;
            out_nxt      = '{extent_start: ext_start, extent_length: ext_len,
                             extent_index: ext_rd_idx,
                             last: (ext_rd_idx == ext_stat.last_idx),
                             status: bea_pkg::ST_OK, used_blocks: used_r};
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      log_r       <= 5'd12;
      total_r     <= 17'd65536;
      cursor_r    <= '0;
      used_r      <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      log_r       <= log_nxt;
      total_r     <= total_nxt;
      cursor_r    <= cursor_nxt;
      used_r      <= used_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mk_addr_r    <= mk_addr_nxt;
    mk_rem_r     <= mk_rem_nxt;
    limit_r      <= limit_nxt;
    al_rem_r     <= al_rem_nxt;
    word_r       <= word_nxt;
    word_addr_r  <= word_addr_nxt;
    wb_ok_r      <= wb_ok_nxt;
    wb_cont_r    <= wb_cont_nxt;
    res_status_r <= res_status_nxt;
    emit_idx_r   <= emit_idx_nxt;
    out_r        <= out_nxt;
  end

  a_out_only_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_EMIT))
    else $error("result word held outside the emit state");

  a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != bea_pkg::ST_OK) |-> out_r.last)
    else $error("failure result not flagged as last");

  a_take_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    ext_ctl.take |-> !cur_oob)
    else $error("block taken beyond the bitmap");

  a_ext_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (4'(ext_stat.last_idx) < 4'(EXT_LIMIT)))
    else $error("extent count beyond the limit");

  a_used_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CLEAR) |=> (used_r >= $past(used_r)))
    else $error("used counter went down");

endmodule
